// ===== hw/rtl/iso_tp_frame_reassembler_core_defines.svh =====
// Assertion macros for the ISO-TP frame reassembler.
`ifndef ISO_TP_FRAME_REASSEMBLER_CORE_DEFINES_SVH
`define ISO_TP_FRAME_REASSEMBLER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define ITP_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("itp assertion failed");
`define ITP_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("itp assertion failed");
`else
`define ITP_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons)
`define ITP_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)
`endif
`endif

// ===== hw/rtl/itp_pkg.sv =====
// Shared types and constants for the ISO-TP frame reassembler.
package itp_pkg;

    localparam int NUM_LANES = 7;

    typedef enum logic [2:0] {
        ST_SINGLE   = 3'd0,
        ST_FIRST    = 3'd1,
        ST_WAIT     = 3'd2,
        ST_COMPLETE = 3'd3,
        ST_FLOWCTL  = 3'd4,
        ST_INVALID  = 3'd5
    } status_t;

    localparam logic [3:0] PCI_SF = 4'h0;
    localparam logic [3:0] PCI_FF = 4'h1;
    localparam logic [3:0] PCI_CF = 4'h2;
    localparam logic [3:0] PCI_FC = 4'h3;

    localparam logic [2:0]  SF_MAX_LEN  = 3'd7;
    localparam logic [11:0] FF_MIN_LEN  = 12'd8;
    localparam logic [11:0] FF_RX_COUNT = 12'd6;
    localparam logic [2:0]  FF_BYTES    = 3'd6;
    localparam logic [2:0]  CF_BYTES    = 3'd7;
    localparam logic [3:0]  SEQ_START   = 4'd1;

    typedef struct packed {
        status_t     status;
        logic [11:0] addr;
        logic [2:0]  count;
        logic        shift;
    } ctl_t;

endpackage

// ===== hw/rtl/itp_ctrl.sv =====
// Frame decode and reception state for the ISO-TP reassembler.
module itp_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    frame_byte0,
    input  logic [7:0]    frame_byte1,
    output itp_pkg::ctl_t ctl
);
    import itp_pkg::*;

    logic        receiving_reg, receiving_next;
    logic [11:0] expected_reg, expected_next;
    logic [11:0] received_reg, received_next;
    logic [3:0]  seq_reg, seq_next;

    logic [3:0]  pci_type;
    logic [3:0]  low;
    logic [11:0] ff_len;
    logic [11:0] remain;
    logic [2:0]  cf_n;
    logic [11:0] cf_count;

    assign pci_type = frame_byte0[7:4];
    assign low      = frame_byte0[3:0];
    assign ff_len   = {low, frame_byte1};
    assign remain   = expected_reg - received_reg;
    assign cf_n     = (remain < 12'(CF_BYTES)) ? remain[2:0] : CF_BYTES;
    assign cf_count = received_reg + 12'(cf_n);

    always_comb
    begin
        receiving_next = 1'b0;
        expected_next  = '0;
        received_next  = '0;
        seq_next       = SEQ_START;
        ctl.status     = ST_INVALID;
        ctl.addr       = '0;
        ctl.count      = '0;
        ctl.shift      = 1'b0;
        unique case (pci_type)
            PCI_SF:
            begin
                if (low != 4'd0 && low <= 4'(SF_MAX_LEN))
                begin
                    ctl.status = ST_SINGLE;
                    ctl.count  = low[2:0];
                end
            end
            PCI_FF:
            begin
                if (ff_len >= FF_MIN_LEN)
                begin
                    ctl.status     = ST_FIRST;
                    ctl.count      = FF_BYTES;
                    ctl.shift      = 1'b1;
                    receiving_next = 1'b1;
                    expected_next  = ff_len;
                    received_next  = FF_RX_COUNT;
                end
            end
            PCI_CF:
            begin
                if (receiving_reg && low == seq_reg)
                begin
                    ctl.addr  = received_reg;
                    ctl.count = cf_n;
                    if (cf_count >= expected_reg)
                    begin
                        ctl.status = ST_COMPLETE;
                    end
                    else
                    begin
                        ctl.status     = ST_WAIT;
                        receiving_next = 1'b1;
                        expected_next  = expected_reg;
                        received_next  = cf_count;
                        seq_next       = seq_reg + 4'd1;
                    end
                end
            end
            PCI_FC:
            begin
                ctl.status = ST_FLOWCTL;
            end
            default:
            begin
                ctl.status = ST_INVALID;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiving_reg <= 1'b0;
            expected_reg  <= '0;
            received_reg  <= '0;
            seq_reg       <= SEQ_START;
        end
        else if (accept)
        begin
            receiving_reg <= receiving_next;
            expected_reg  <= expected_next;
            received_reg  <= received_next;
            seq_reg       <= seq_next;
        end
    end

endmodule

// ===== hw/rtl/itp_lane.sv =====
// One payload byte lane: source select and count mask.
module itp_lane #(
    parameter int LANE = 0
) (
    input  logic [7:0] byte_cf,
    input  logic [7:0] byte_ff,
    input  logic       shift,
    input  logic [2:0] count,
    output logic [7:0] data
);
    localparam logic [2:0] LANE_IDX = 3'(LANE);

    always_comb
    begin
        if (LANE_IDX < count)
            data = shift ? byte_ff : byte_cf;
        else
            data = '0;
    end

endmodule

// ===== hw/rtl/iso_tp_frame_reassembler_core.sv =====
// Top level of the ISO-TP receive reassembler for 8-byte CAN frames.
// An accepted input beat is registered into the output register as its result beat.
// Throughput: one frame per cycle while not stalled; decode and lanes are combinational.
// The output register frees when its beat is taken, so input and output can move together.
// Reset (rst_n low, async): idle, no reception, next sequence 1, output register empty.
`include "iso_tp_frame_reassembler_core_defines.svh"
module iso_tp_frame_reassembler_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // frame_byte0 .. frame_byte7
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,  // write_address, byte_count, data0 .. data6, pad
    output logic [2:0]  m_axis_tuser   // status
);
    import itp_pkg::*;

    logic          in_beat;
    logic          out_beat;
    ctl_t          ctl;
    logic [7:0]    frame [8];
    logic [7:0]    lane_data [NUM_LANES];

    logic          valid_reg;
    status_t       status_reg;
    logic [11:0]   addr_reg;
    logic [2:0]    count_reg;
    logic [7:0]    data_reg [NUM_LANES];

    assign s_axis_tready = !valid_reg || m_axis_tready;
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_beat      = valid_reg && m_axis_tready;

    for (genvar i = 0; i < 8; i++)
    begin : g_bytes
        assign frame[i] = s_axis_tdata[8*i +: 8];
    end

    itp_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_beat),
        .frame_byte0 (frame[0]),
        .frame_byte1 (frame[1]),
        .ctl         (ctl)
    );

    for (genvar k = 0; k < NUM_LANES; k++)
    begin : g_lane
        itp_lane #(
            .LANE (k)
        ) u_lane (
            .byte_cf (frame[k + 1]),
            .byte_ff ((k + 2 < 8) ? frame[(k + 2) % 8] : 8'h00),
            .shift   (ctl.shift),
            .count   (ctl.count),
            .data    (lane_data[k])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_beat)
            valid_reg <= 1'b1;
        else if (out_beat)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            status_reg <= ctl.status;
            addr_reg   <= ctl.addr;
            count_reg  <= ctl.count;
            data_reg   <= lane_data;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = {1'b0, data_reg[6], data_reg[5], data_reg[4], data_reg[3],
                            data_reg[2], data_reg[1], data_reg[0], count_reg, addr_reg};

    `ITP_ASSERT_SAME(a_stall_blocks_input, clk, rst_n, valid_reg && !m_axis_tready, !s_axis_tready)
    `ITP_ASSERT_SAME(a_no_payload, clk, rst_n,
        valid_reg && (status_reg == ST_INVALID || status_reg == ST_FLOWCTL),
        addr_reg == 12'd0 && count_reg == 3'd0)
    `ITP_ASSERT_SAME(a_first_count, clk, rst_n,
        valid_reg && status_reg == ST_FIRST, count_reg == FF_BYTES && addr_reg == 12'd0)
    `ITP_ASSERT_NEXT(a_drain, clk, rst_n, out_beat && !in_beat, !valid_reg)

endmodule

// ===== verif/tb_iso_tp_frame_reassembler_core.sv =====
// Testbench for the ISO-TP receive reassembler: directed and random CAN frames, scoreboard check.
`timescale 1ns / 1ps
module tb_iso_tp_frame_reassembler_core;
    import itp_pkg::*;

    localparam int ITEM_TARGET = 1850;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        status_t          status;
        logic [11:0]      addr;
        logic [2:0]       count;
        logic [6:0][7:0]  data;
    } rx_result_t;

    class isotp_rx_scoreboard;
        rx_result_t  expected_results[$];
        int          errors = 0;
        logic        receiving = 1'b0;
        logic [11:0] msg_length = '0;
        logic [11:0] bytes_seen = '0;
        logic [3:0]  next_seq = SEQ_START;

        function void go_idle();
            receiving = 1'b0;
            msg_length = '0;
            bytes_seen = '0;
            next_seq = SEQ_START;
        endfunction

        function rx_result_t reassemble(logic [63:0] frame);
            rx_result_t  r;
            logic [3:0]  pci_type;
            logic [3:0]  pci_low;
            logic [11:0] ff_len;
            logic [11:0] remain;
            logic [2:0]  n;
            r = '0;
            pci_type = frame[7:4];
            pci_low = frame[3:0];
            r.status = ST_INVALID;
            if (pci_type == PCI_SF) begin
                go_idle();
                if (pci_low != 4'd0 && pci_low <= 4'd7) begin
                    r.status = ST_SINGLE;
                    r.count = pci_low[2:0];
                    for (int k = 0; k < 7; k++)
                        if (k < pci_low) r.data[k] = frame[8 + 8 * k +: 8];
                end
            end else if (pci_type == PCI_FF) begin
                ff_len = {pci_low, frame[15:8]};
                go_idle();
                if (ff_len >= FF_MIN_LEN) begin
                    receiving = 1'b1;
                    msg_length = ff_len;
                    bytes_seen = FF_RX_COUNT;
                    r.status = ST_FIRST;
                    r.count = FF_BYTES;
                    for (int k = 0; k < 6; k++) r.data[k] = frame[16 + 8 * k +: 8];
                end
            end else if (pci_type == PCI_CF) begin
                if (!receiving || pci_low != next_seq) begin
                    go_idle();
                end else begin
                    remain = msg_length - bytes_seen;
                    n = (remain < 12'd7) ? remain[2:0] : CF_BYTES;
                    r.addr = bytes_seen;
                    r.count = n;
                    for (int k = 0; k < 7; k++)
                        if (k < n) r.data[k] = frame[8 + 8 * k +: 8];
                    bytes_seen = bytes_seen + 12'(n);
                    next_seq = next_seq + 4'd1;
                    if (bytes_seen >= msg_length) begin
                        go_idle();
                        r.status = ST_COMPLETE;
                    end else begin
                        r.status = ST_WAIT;
                    end
                end
            end else if (pci_type == PCI_FC) begin
                go_idle();
                r.status = ST_FLOWCTL;
            end else begin
                go_idle();
            end
            return r;
        endfunction

        function void note_frame(logic [63:0] frame);
            expected_results.push_back(reassemble(frame));
        endfunction

        function void check_beat(logic [2:0] user, logic [71:0] tdata);
            rx_result_t e;
            if (expected_results.size() == 0) begin
                $error("result beat with no expectation: tuser=%0d tdata=%h", user, tdata);
                errors++;
                return;
            end
            e = expected_results.pop_front();
            if (user !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, user);
                errors++;
            end
            if (tdata[11:0] !== e.addr) begin
                $error("write_address: expected %0d, got %0d", e.addr, tdata[11:0]);
                errors++;
            end
            if (tdata[14:12] !== e.count) begin
                $error("byte_count: expected %0d, got %0d", e.count, tdata[14:12]);
                errors++;
            end
            for (int k = 0; k < 7; k++)
                if (tdata[15 + 8 * k +: 8] !== e.data[k]) begin
                    $error("data%0d: expected %h, got %h", k, e.data[k],
                           tdata[15 + 8 * k +: 8]);
                    errors++;
                end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;

    isotp_rx_scoreboard sb = new;
    int  items_sent = 0;
    int  big_messages = 0;
    int  cycles = 0;
    logic steady = 1'b0;

    iso_tp_frame_reassembler_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
        if (rst_n && s_axis_tvalid && s_axis_tready) sb.note_frame(s_axis_tdata);
        if (rst_n && m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tuser, m_axis_tdata);
    end

    always @(negedge clk)
    begin
        if (!rst_n) m_axis_tready <= 1'b0;
        else m_axis_tready <= steady || ($urandom_range(99) >= 34);
    end

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_frame(input logic [63:0] frame);
        while (!steady && $urandom_range(99) < 34) begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = frame;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
        items_sent++;
        steady = (items_sent >= 800 && items_sent < 1100);
    endtask

    function automatic logic [63:0] mk_frame(logic [3:0] pci_type, logic [3:0] pci_low);
        logic [63:0] f;
        f = {$urandom(), $urandom()};
        f[7:0] = {pci_type, pci_low};
        return f;
    endfunction

    function automatic logic [63:0] mk_ff(logic [11:0] len);
        logic [63:0] f;
        f = mk_frame(PCI_FF, len[11:8]);
        f[15:8] = len[7:0];
        return f;
    endfunction

    task automatic send_message();
        logic [11:0] len;
        logic [11:0] got;
        logic [3:0]  seq;
        if (big_messages < 4 && $urandom_range(199) == 0) begin
            len = 12'($urandom_range(3000, 4095));
            big_messages++;
        end else begin
            len = 12'($urandom_range(8, 130));
        end
        send_frame(mk_ff(len));
        got = FF_RX_COUNT;
        seq = SEQ_START;
        while (got < len) begin
            if ($urandom_range(99) < 3) begin
                case ($urandom_range(3))
                    0: send_frame(mk_frame(PCI_CF, seq + 4'($urandom_range(1, 15))));
                    1: send_frame(mk_frame(PCI_SF, 4'($urandom_range(1, 7))));
                    2: send_frame(mk_frame(PCI_FC, 4'($urandom())));
                    default: ;
                endcase
                return;
            end
            send_frame(mk_frame(PCI_CF, seq));
            got = got + ((len - got < 12'd7) ? (len - got) : 12'd7);
            seq = seq + 4'd1;
        end
    endtask

    initial
    begin
        int r;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed frames
        send_frame(64'hFFFF_FFFF_FFFF_FF01);
        send_frame(64'hFFFF_FFFF_FFFF_FF07);
        send_frame(64'h0000_0000_0000_0007);
        send_frame(mk_frame(PCI_SF, 4'h0));
        send_frame(mk_frame(PCI_SF, 4'h8));
        send_frame(64'hFFFF_FFFF_FFFF_FF0F);
        send_frame(mk_ff(12'd7));
        send_frame(mk_ff(12'd8));
        send_frame(mk_frame(PCI_CF, 4'h1));
        send_frame(mk_frame(PCI_CF, 4'h1));
        send_frame(mk_ff(12'd20));
        send_frame(mk_frame(PCI_CF, 4'h1));
        send_frame(mk_frame(PCI_CF, 4'h2));
        send_frame(mk_ff(12'hFFF));
        send_frame(mk_frame(PCI_CF, 4'h2));
        send_frame(mk_ff(12'd30));
        send_frame(mk_frame(PCI_CF, 4'h1));
        send_frame(mk_frame(PCI_SF, 4'h3));
        send_frame(mk_frame(PCI_CF, 4'h2));
        send_frame(mk_ff(12'd40));
        send_frame(mk_ff(12'd9));
        send_frame(mk_frame(PCI_CF, 4'h1));
        send_frame(mk_frame(PCI_FC, 4'h0));
        send_frame(mk_frame(4'h4, 4'h0));
        send_frame(64'hFFFF_FFFF_FFFF_FFFF);

        while (items_sent < ITEM_TARGET) begin
            r = $urandom_range(99);
            if (r < 60) begin
                send_message();
            end else if (r < 80) begin
                if ($urandom_range(9) == 0)
                    send_frame(mk_frame(PCI_SF, ($urandom_range(1) != 0) ? 4'h0
                                                 : 4'($urandom_range(8, 15))));
                else
                    send_frame(mk_frame(PCI_SF, 4'($urandom_range(1, 7))));
            end else begin
                send_frame({$urandom(), $urandom()});
            end
        end
        s_axis_tvalid = 1'b0;

        while (sb.expected_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
